// ----- src/cda_pkg.sv -----
`default_nettype none
package cda_pkg;

   localparam logic [1:0] ERR_NONE  = 2'd0;
   localparam logic [1:0] ERR_SET   = 2'd1;
   localparam logic [1:0] ERR_RANGE = 2'd2;

   localparam int unsigned DAY_SEC     = 86400;
   localparam int unsigned OFFSET_DAYS = 24856;
   localparam logic [32:0] OFFSET_SEC  = 33'(64'(OFFSET_DAYS) * 64'(DAY_SEC));
   localparam logic [13:0] YEAR_MIN    = 14'd1;
   localparam logic [13:0] YEAR_MAX    = 14'd9999;

   typedef struct packed {
      logic do_set;
      logic load;
      logic div_step;
      logic tod_step;
      logic walk_step;
   } cmd_type;

   typedef struct packed {
      logic div_last;
      logic tod_fin;
      logic walk_fin;
      logic walk_bad;
   } sts_type;

   // y % 25 via reciprocal multiply, exact for 14-bit years
   function automatic logic is_leap(input logic [13:0] y);
      logic [26:0] prod;
      logic [9:0]  q25;
      logic [13:0] r25;
      begin
         prod    = 27'(y) * 27'd5243;
         q25     = prod[26:17];
         r25     = y - 14'(q25) * 14'd25;
         is_leap = (y[1:0] == 2'b00) && ((r25 != 14'd0) || (y[3:0] == 4'd0));
      end
   endfunction

   function automatic logic [4:0] days_in_month(input logic [3:0] m, input logic [13:0] y);
      begin
         case (m)
            4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: days_in_month = 5'd31;
            4'd4, 4'd6, 4'd9, 4'd11:                     days_in_month = 5'd30;
            4'd2:    days_in_month = is_leap(y) ? 5'd29 : 5'd28;
            default: days_in_month = 5'd0;
         endcase
      end
   endfunction

endpackage
`default_nettype wire

// ----- src/cda_ctrl.sv -----
`default_nettype none
module cda_ctrl (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   input  wire logic             req_command,
   output logic                  req_stall,
   output logic                  rsp_valid,
   input  wire logic             rsp_stall,
   input  wire cda_pkg::sts_type sts,
   output cda_pkg::cmd_type      cmd
);
   localparam logic [2:0] S_IDLE = 3'd0;
   localparam logic [2:0] S_DIV  = 3'd1;
   localparam logic [2:0] S_TOD  = 3'd2;
   localparam logic [2:0] S_WALK = 3'd3;
   localparam logic [2:0] S_OUT  = 3'd4;

   logic [2:0] state_ff, state_in;

   assign req_stall = (state_ff != S_IDLE);
   assign rsp_valid = (state_ff == S_OUT);

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               if (req_command) begin
                  cmd.load = 1'b1;
                  state_in = S_DIV;
               end else begin
                  cmd.do_set = 1'b1;
                  state_in   = S_OUT;
               end
            end
         end
         S_DIV: begin
            cmd.div_step = 1'b1;
            if (sts.div_last) state_in = S_TOD;
         end
         S_TOD: begin
            cmd.tod_step = 1'b1;
            if (sts.tod_fin) state_in = S_WALK;
         end
         S_WALK: begin
            cmd.walk_step = 1'b1;
            if (sts.walk_fin || sts.walk_bad) state_in = S_OUT;
         end
         S_OUT: begin
            if (!rsp_stall) state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= S_IDLE;
      else       state_ff <= state_in;
   end
endmodule
`default_nettype wire

// ----- src/cda_datapath.sv -----
`default_nettype none
module cda_datapath (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire cda_pkg::cmd_type   cmd,
   output cda_pkg::sts_type        sts,
   input  wire logic signed [31:0] req_delta_seconds,
   input  wire logic [13:0]        req_set_year,
   input  wire logic [3:0]         req_set_month,
   input  wire logic [4:0]         req_set_day,
   input  wire logic [4:0]         req_set_hour,
   input  wire logic [5:0]         req_set_minute,
   input  wire logic [5:0]         req_set_second,
   output logic [13:0]             rsp_cur_year,
   output logic [3:0]              rsp_cur_month,
   output logic [4:0]              rsp_cur_day,
   output logic [4:0]              rsp_cur_hour,
   output logic [5:0]              rsp_cur_minute,
   output logic [5:0]              rsp_cur_second,
   output logic [1:0]              rsp_error_code
);
   logic [13:0] year_ff;
   logic [3:0]  month_ff;
   logic [4:0]  day_ff, hour_ff;
   logic [5:0]  minute_ff, second_ff;
   logic [1:0]  err_ff;

   logic [32:0] rem_ff;
   logic [15:0] quo_ff;
   logic [3:0]  cnt_ff;
   logic [4:0]  wh_ff;
   logic [5:0]  wmi_ff, wsec_ff;
   logic [13:0] wy_ff;
   logic [3:0]  wm_ff;
   logic [4:0]  wd_ff;
   logic [15:0] days_ff;
   logic        fwd_ff;

   assign rsp_cur_year   = year_ff;
   assign rsp_cur_month  = month_ff;
   assign rsp_cur_day    = day_ff;
   assign rsp_cur_hour   = hour_ff;
   assign rsp_cur_minute = minute_ff;
   assign rsp_cur_second = second_ff;
   assign rsp_error_code = err_ff;

   // set check
   logic set_ok;
   always_comb begin
      set_ok = (req_set_year >= cda_pkg::YEAR_MIN) && (req_set_year <= cda_pkg::YEAR_MAX)
             && (req_set_day != 5'd0)
             && (req_set_day <= cda_pkg::days_in_month(req_set_month, req_set_year))
             && (req_set_hour < 5'd24) && (req_set_minute < 6'd60)
             && (req_set_second < 6'd60);
   end

   // seconds of day plus delta, biased positive (true sum fits in 33 bits)
   logic [16:0] hms;
   logic [32:0] tod_sum;
   assign hms     = 17'(hour_ff) * 17'd3600 + 17'(minute_ff) * 17'd60 + 17'(second_ff);
   assign tod_sum = 33'(hms) + {req_delta_seconds[31], req_delta_seconds}
                  + cda_pkg::OFFSET_SEC;

   // restoring divide by seconds per day
   logic [32:0] div_sh;
   logic        div_ge;
   assign div_sh = 33'(cda_pkg::DAY_SEC) << cnt_ff;
   assign div_ge = (rem_ff >= div_sh);

   // month walk
   logic [4:0]  mlen, plen, step_len;
   logic [16:0] fsum;
   logic        fits, bfits;
   logic [3:0]  pm;
   logic [13:0] py;
   always_comb begin
      mlen     = cda_pkg::days_in_month(wm_ff, wy_ff);
      fsum     = 17'(wd_ff) + 17'(days_ff);
      fits     = (fsum <= 17'(mlen));
      step_len = mlen - wd_ff + 5'd1;
      bfits    = (days_ff < 16'(wd_ff));
      if (wm_ff == 4'd1) begin
         pm = 4'd12;
         py = wy_ff - 14'd1;
      end else begin
         pm = wm_ff - 4'd1;
         py = wy_ff;
      end
      plen = cda_pkg::days_in_month(pm, py);
   end

   always_comb begin
      sts.div_last = (cnt_ff == 4'd0);
      sts.tod_fin  = (rem_ff[16:0] < 17'd60);
      if (fwd_ff) begin
         sts.walk_fin = fits;
         sts.walk_bad = !fits && (wm_ff == 4'd12) && (wy_ff == cda_pkg::YEAR_MAX);
      end else begin
         sts.walk_fin = bfits;
         sts.walk_bad = !bfits && (wm_ff == 4'd1) && (wy_ff == cda_pkg::YEAR_MIN);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         year_ff   <= 14'd1;
         month_ff  <= 4'd1;
         day_ff    <= 5'd1;
         hour_ff   <= 5'd0;
         minute_ff <= 6'd0;
         second_ff <= 6'd0;
         err_ff    <= cda_pkg::ERR_NONE;
      end else begin
         if (cmd.do_set) begin
            if (set_ok) begin
               year_ff   <= req_set_year;
               month_ff  <= req_set_month;
               day_ff    <= req_set_day;
               hour_ff   <= req_set_hour;
               minute_ff <= req_set_minute;
               second_ff <= req_set_second;
               err_ff    <= cda_pkg::ERR_NONE;
            end else begin
               err_ff <= cda_pkg::ERR_SET;
            end
         end
         if (cmd.load) err_ff <= cda_pkg::ERR_NONE;
         if (cmd.walk_step) begin
            if (sts.walk_fin) begin
               year_ff   <= wy_ff;
               month_ff  <= wm_ff;
               day_ff    <= fwd_ff ? fsum[4:0] : (wd_ff - days_ff[4:0]);
               hour_ff   <= wh_ff;
               minute_ff <= wmi_ff;
               second_ff <= wsec_ff;
            end else if (sts.walk_bad) begin
               err_ff <= cda_pkg::ERR_RANGE;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         rem_ff  <= tod_sum;
         quo_ff  <= '0;
         cnt_ff  <= 4'd15;
         wh_ff   <= '0;
         wmi_ff  <= '0;
         wsec_ff <= '0;
         wy_ff   <= year_ff;
         wm_ff   <= month_ff;
         wd_ff   <= day_ff;
      end
      if (cmd.div_step) begin
         if (div_ge) begin
            rem_ff         <= rem_ff - div_sh;
            quo_ff[cnt_ff] <= 1'b1;
         end
         cnt_ff <= cnt_ff - 4'd1;
      end
      if (cmd.tod_step) begin
         if (quo_ff >= 16'(cda_pkg::OFFSET_DAYS)) begin
            fwd_ff  <= 1'b1;
            days_ff <= quo_ff - 16'(cda_pkg::OFFSET_DAYS);
         end else begin
            fwd_ff  <= 1'b0;
            days_ff <= 16'(cda_pkg::OFFSET_DAYS) - quo_ff;
         end
         if (rem_ff[16:0] >= 17'd3600) begin
            rem_ff <= rem_ff - 33'd3600;
            wh_ff  <= wh_ff + 5'd1;
         end else if (rem_ff[16:0] >= 17'd60) begin
            rem_ff <= rem_ff - 33'd60;
            wmi_ff <= wmi_ff + 6'd1;
         end else begin
            wsec_ff <= rem_ff[5:0];
         end
      end
      if (cmd.walk_step && !sts.walk_fin && !sts.walk_bad) begin
         if (fwd_ff) begin
            days_ff <= days_ff - 16'(step_len);
            wd_ff   <= 5'd1;
            if (wm_ff == 4'd12) begin
               wm_ff <= 4'd1;
               wy_ff <= wy_ff + 14'd1;
            end else begin
               wm_ff <= wm_ff + 4'd1;
            end
         end else begin
            days_ff <= days_ff - 16'(wd_ff);
            wm_ff   <= pm;
            wy_ff   <= py;
            wd_ff   <= plen;
         end
      end
   end
endmodule
`default_nettype wire

// ----- src/calendar_datetime_adjust.sv -----
`default_nettype none
// Holds a Gregorian date and time, reset to 0001-01-01 00:00:00. A set beat
// (command 0) checks and loads the set_* fields and answers in the next cycle;
// invalid values keep the held value and return error 1. An add beat
// (command 1) moves the held value by delta_seconds: a restoring divide by
// 86400 into days, then hours and minutes are peeled off the remainder,
// then a day walk steps across each month boundary in turn. A result
// outside years 1..9999 keeps the held value and returns error 2. One beat
// is in flight at a time; req_stall is high from acceptance until the
// result beat is taken.
module calendar_datetime_adjust (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output logic                    req_stall,
   input  wire logic               req_command,
   input  wire logic signed [31:0] req_delta_seconds,
   input  wire logic [13:0]        req_set_year,
   input  wire logic [3:0]         req_set_month,
   input  wire logic [4:0]         req_set_day,
   input  wire logic [4:0]         req_set_hour,
   input  wire logic [5:0]         req_set_minute,
   input  wire logic [5:0]         req_set_second,
   output logic                    rsp_valid,
   input  wire logic               rsp_stall,
   output logic [13:0]             rsp_cur_year,
   output logic [3:0]              rsp_cur_month,
   output logic [4:0]              rsp_cur_day,
   output logic [4:0]              rsp_cur_hour,
   output logic [5:0]              rsp_cur_minute,
   output logic [5:0]              rsp_cur_second,
   output logic [1:0]              rsp_error_code
);
   cda_pkg::cmd_type cmd;
   cda_pkg::sts_type sts;

   // sequencer: idle, divide, time of day, month walk, result
   cda_ctrl u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_command (req_command),
      .req_stall   (req_stall),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .sts         (sts),
      .cmd         (cmd)
   );

   // held date/time, divider and walker
   cda_datapath u_dp (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .sts               (sts),
      .req_delta_seconds (req_delta_seconds),
      .req_set_year      (req_set_year),
      .req_set_month     (req_set_month),
      .req_set_day       (req_set_day),
      .req_set_hour      (req_set_hour),
      .req_set_minute    (req_set_minute),
      .req_set_second    (req_set_second),
      .rsp_cur_year      (rsp_cur_year),
      .rsp_cur_month     (rsp_cur_month),
      .rsp_cur_day       (rsp_cur_day),
      .rsp_cur_hour      (rsp_cur_hour),
      .rsp_cur_minute    (rsp_cur_minute),
      .rsp_cur_second    (rsp_cur_second),
      .rsp_error_code    (rsp_error_code)
   );
endmodule
`default_nettype wire
